>>> src/assert_macros.svh
// Assertion helpers shared by the decoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

>>> src/isfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isfd_pkg
// Types and constants shared by the IMU serial frame decoder.
// ----------------------------------------------------------------------------
package isfd_pkg;

  // Byte codes
  localparam logic [7:0] SyncByte  = 8'h55;
  localparam logic [7:0] TypeFirst = 8'h51;
  localparam logic [7:0] TypeLast  = 8'h54;

  // Frame positions: 0 hunting, 1 type byte, 2..10 payload bytes
  localparam logic [3:0] PosHunt    = 4'd0;
  localparam logic [3:0] PosType    = 4'd1;
  localparam logic [3:0] PosPayload = 4'd2;
  localparam logic [3:0] PosLast    = 4'd10;

  // Payload bytes kept for decoding (three 16-bit channels)
  localparam int unsigned KeptBytes = 6;
  localparam int unsigned Channels  = 3;

  // Scaling thresholds (raw units) and offsets (output units, value * 256)
  localparam logic signed [15:0] AccelThresh = 16'sd20480;
  localparam logic signed [15:0] RateThresh  = 16'sd8192;
  localparam logic signed [25:0] AccelOffset = 26'sd8192;
  localparam logic signed [25:0] RateOffset  = 26'sd1024000;

  typedef enum logic [1:0] {
    KIND_ACCEL = 2'd0,
    KIND_RATE  = 2'd1,
    KIND_ANGLE = 2'd2,
    KIND_MAG   = 2'd3
  } kind_t;

  // One complete frame handed to the scaling stage
  typedef struct packed {
    kind_t                      kind;
    logic [KeptBytes-1:0][7:0]  payload;
  } frame_t;

endpackage

>>> src/imu_serial_frame_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_serial_frame_decoder
// Byte-stream decoder for 11-byte IMU frames giving scaled three-axis data.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries received serial bytes, one per request, in s_tdata[7:0].
//   m_* carries one decoded sample per frame of a known type:
//   m_tdata holds axis_x, axis_y, axis_z (24-bit signed, value * 256) and
//   m_tuser the kind (0 accel, 1 rate, 2 angle, 3 magnetic).
//   Bytes before a sync byte are dropped; frames of unknown type give no
//   output. Checksum and temperature bytes are not used.
//   Throughput: one byte per cycle while s_tready is high. The frame register and the output
//   register form a two-entry pipeline, so a byte is still taken while a
//   finished sample waits on m_tready.
//   The closing byte loads the frame register; the scaled sample then moves
//   into the output register, raising m_tvalid, once that register is free.
//   When m_tready stays low, s_tready drops as soon as both registers hold
//   a sample.
//   Reset (rst, synchronous) returns to hunting and empties the pipeline.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module imu_serial_frame_decoder (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] rx_byte
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [71:0]  m_tdata,   // [23:0] axis_x, [47:24] axis_y, [71:48] axis_z
  output logic [1:0]   m_tuser    // [1:0] kind
);
  import isfd_pkg::*;

  logic                      frame_valid;
  logic                      frame_ready;
  frame_t                    frame;
  logic                      out_ready;
  logic [Channels-1:0][23:0] scaled;
  logic [Channels-1:0][23:0] axis;
  kind_t                     kind;

  isfd_frame_assembler u_assembler (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (s_tvalid),
    .byte_ready  (s_tready),
    .rx_byte     (s_tdata),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame)
  );

  // One scaler per channel, little-endian byte pairs
  for (genvar c = 0; c < Channels; c++) begin : g_axis
    isfd_axis_scaler u_scaler (
      .kind (frame.kind),
      .raw  ({frame.payload[2*c+1], frame.payload[2*c]}),
      .axis (scaled[c])
    );
  end

  // Output register
  assign out_ready   = !m_tvalid || m_tready;
  assign frame_ready = out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_tvalid <= frame_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_valid && out_ready) begin
      axis <= scaled;
      kind <= frame.kind;
    end
  end

  assign m_tdata = axis;
  assign m_tuser = kind;

  // Checks
  `ASSERT_CLK(a_empty_takes_input, clk, rst, !m_tvalid |-> s_tready)
  `ASSERT_CLK(a_frame_moves_out, clk, rst, frame_valid && out_ready |=> m_tvalid)
  `ASSERT_CLK(a_stall_holds_frame, clk, rst,
              m_tvalid && !m_tready && frame_valid |=> frame_valid && $stable(frame))

endmodule

>>> src/isfd_frame_assembler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isfd_frame_assembler
// Hunts for the sync byte, collects type and payload, and loads a frame
// register when a frame of a known type closes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module isfd_frame_assembler (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_ready,
  input  logic [7:0]          rx_byte,
  output logic                frame_valid,
  input  logic                frame_ready,
  output isfd_pkg::frame_t    frame
);
  import isfd_pkg::*;

  logic [3:0]                 pos;
  logic [3:0]                 pos_next;
  logic [7:0]                 frame_type;
  logic [KeptBytes-1:0][7:0]  payload;
  logic                       accept;
  logic                       type_known;
  logic                       frame_done;
  logic [7:0]                 type_offset;

  assign byte_ready = !frame_valid || frame_ready;
  assign accept     = byte_valid && byte_ready;

  // Type decode
  assign type_known  = (frame_type >= TypeFirst) && (frame_type <= TypeLast);
  assign type_offset = frame_type - TypeFirst;
  assign frame_done  = accept && (pos == PosLast) && type_known;

  // Position sequencer
  always_comb begin
    pos_next = pos;
    if (accept) begin
      if (pos == PosHunt || pos > PosLast) begin
        pos_next = (rx_byte == SyncByte) ? PosType : PosHunt;
      end else if (pos == PosLast) begin
        pos_next = PosHunt;
      end else begin
        pos_next = pos + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= PosHunt;
      frame_type <= '0;
    end else begin
      pos <= pos_next;
      if (accept && pos == PosType) begin
        frame_type <= rx_byte;
      end
    end
  end

  // Payload capture, one register per kept byte
  for (genvar i = 0; i < KeptBytes; i++) begin : g_payload
    always_ff @(posedge clk) begin
      if (accept && pos == PosPayload + 4'(i)) begin
        payload[i] <= rx_byte;
      end
    end
  end

  // Frame register towards the scaler
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (frame_done) begin
      frame_valid <= 1'b1;
    end else if (frame_ready) begin
      frame_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_done) begin
      frame.kind    <= kind_t'(type_offset[1:0]);
      frame.payload <= payload;
    end
  end

  // Checks
  `ASSERT_CLK(a_pos_range, clk, rst, pos <= PosLast)
  `ASSERT_CLK(a_frame_held, clk, rst, frame_valid && !frame_ready |=> frame_valid)
  `ASSERT_CLK(a_frame_from_last, clk, rst,
              $rose(frame_valid) |-> $past(pos) == PosLast && $past(accept))

endmodule

>>> src/isfd_axis_scaler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isfd_axis_scaler
// Scales one raw 16-bit channel to fixed point with 8 fraction bits,
// rounding toward minus infinity, with the per-kind offset correction.
// ----------------------------------------------------------------------------
module isfd_axis_scaler (
  input  isfd_pkg::kind_t     kind,
  input  logic signed [15:0]  raw,
  output logic signed [23:0]  axis
);
  import isfd_pkg::*;

  logic signed [25:0] r;
  logic signed [25:0] rate_prod;
  logic signed [25:0] angle_prod;
  logic signed [25:0] q;

  assign r = 26'(raw);

  // r*125 and r*45 from shifted copies
  assign rate_prod  = (r <<< 7) - (r <<< 1) - r;
  assign angle_prod = (r <<< 5) + (r <<< 3) + (r <<< 2) + r;

  // Arithmetic shifts floor toward minus infinity; angle and magnetic
  // kinds have no threshold and no offset correction.
  always_comb begin
    unique case (kind)
      KIND_ACCEL: begin
        q = r >>> 3;
        if (raw > AccelThresh) begin
          q = q - AccelOffset;
        end
      end
      KIND_RATE: begin
        q = rate_prod >>> 3;
        if (raw > RateThresh) begin
          q = q - RateOffset;
        end
      end
      KIND_ANGLE: q = angle_prod >>> 5;
      KIND_MAG:   q = r <<< 8;
    endcase
  end

  assign axis = q[23:0];

endmodule
